>>> rtl/cofu_pkg.sv
package cofu_pkg;

   // register selector codes
   localparam logic [3:0] SEL_NONE = 4'd0;
   localparam logic [3:0] SEL_A    = 4'd1;
   localparam logic [3:0] SEL_C    = 4'd4;
   localparam logic [3:0] SEL_L    = 4'd8;
   localparam logic [3:0] SEL_AF   = 4'd9;
   localparam logic [3:0] SEL_HL   = 4'd12;
   localparam logic [3:0] SEL_SP   = 4'd13;
   localparam logic [3:0] SEL_PC   = 4'd14;

   // addressing modes
   localparam logic [4:0] M_IMP    = 5'd0;
   localparam logic [4:0] M_R      = 5'd1;
   localparam logic [4:0] M_R_R    = 5'd2;
   localparam logic [4:0] M_R_D8   = 5'd3;
   localparam logic [4:0] M_R_D16  = 5'd4;
   localparam logic [4:0] M_D16    = 5'd5;
   localparam logic [4:0] M_MR_R   = 5'd6;
   localparam logic [4:0] M_R_MR   = 5'd7;
   localparam logic [4:0] M_R_HLI  = 5'd8;
   localparam logic [4:0] M_R_HLD  = 5'd9;
   localparam logic [4:0] M_HLI_R  = 5'd10;
   localparam logic [4:0] M_HLD_R  = 5'd11;
   localparam logic [4:0] M_R_A8   = 5'd12;
   localparam logic [4:0] M_A8_R   = 5'd13;
   localparam logic [4:0] M_HL_SPR = 5'd14;
   localparam logic [4:0] M_D8     = 5'd15;
   localparam logic [4:0] M_A16_R  = 5'd16;
   localparam logic [4:0] M_D16_R  = 5'd17;
   localparam logic [4:0] M_MR_D8  = 5'd18;
   localparam logic [4:0] M_MR     = 5'd19;
   localparam logic [4:0] M_R_A16  = 5'd20;

   // request actions
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_DATA  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_BUS_REQ = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;

   localparam logic [15:0] HIGH_PAGE = 16'hFF00;

   // A,F,B,C,D,E,H,L in entries 0..7
   typedef logic [7:0][7:0] byte_file_type;

   typedef struct packed {
      byte_file_type regs;
      logic [15:0]   sp;
      logic [15:0]   pc;
   } arch_type;

   // classified request beat
   typedef struct packed {
      logic [1:0]  op;
      logic        has_instr;
      logic        mode_bad;
      logic [4:0]  mode;
      logic [3:0]  first_sel;
      logic [3:0]  second_sel;
      logic [7:0]  bus_byte;
      logic [3:0]  write_sel;
      logic [15:0] write_value;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] bus_address;
      logic [15:0] operand_value;
      logic [15:0] dest_address;
      logic        dest_is_memory;
   } result_type;

   // register file read by selector
   function automatic logic [15:0] read_reg(arch_type a, logic [3:0] sel);
      logic [3:0]  off;
      logic [2:0]  idx;
      logic [15:0] v;
      off = sel - SEL_AF;
      idx = 3'(sel - SEL_A);
      v   = '0;
      case (sel) inside
         [SEL_A:SEL_L]:   v = {8'h00, a.regs[idx]};
         [SEL_AF:SEL_HL]: v = {a.regs[{off[1:0], 1'b0}], a.regs[{off[1:0], 1'b1}]};
         SEL_SP:          v = a.sp;
         SEL_PC:          v = a.pc;
         default:         v = '0;
      endcase
      return v;
   endfunction

   // register file write by selector
   function automatic arch_type write_reg(arch_type a, logic [3:0] sel, logic [15:0] v);
      logic [3:0] off;
      logic [2:0] idx;
      arch_type   r;
      off = sel - SEL_AF;
      idx = 3'(sel - SEL_A);
      r   = a;
      case (sel) inside
         [SEL_A:SEL_L]: r.regs[idx] = v[7:0];
         [SEL_AF:SEL_HL]: begin
            r.regs[{off[1:0], 1'b0}] = v[15:8];
            r.regs[{off[1:0], 1'b1}] = v[7:0];
         end
         SEL_SP:  r.sp = v;
         SEL_PC:  r.pc = v;
         default: r = a;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/cofu_fifo.sv
module cofu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/cofu_front.sv
module cofu_front (
   input  logic               req_push,
   input  logic               queue_full,
   input  logic [1:0]         req_action,
   input  logic               req_has_instruction,
   input  logic [4:0]         req_addr_mode,
   input  logic [3:0]         req_first_reg,
   input  logic [3:0]         req_second_reg,
   input  logic [7:0]         req_bus_byte,
   input  logic [3:0]         req_write_reg,
   input  logic [15:0]        req_write_value,
   output logic               enq_valid,
   output cofu_pkg::item_type enq_item
);

   logic known_action;

   // beats with an unused action leave no trace and are dropped here
   assign known_action = (req_action == cofu_pkg::ACT_START) ||
                         (req_action == cofu_pkg::ACT_DATA)  ||
                         (req_action == cofu_pkg::ACT_WRITE);
   assign enq_valid    = req_push && !queue_full && known_action;

   // classify the beat for the back end
   always_comb begin
      enq_item.op          = req_action;
      enq_item.has_instr   = req_has_instruction;
      enq_item.mode_bad    = (req_addr_mode > cofu_pkg::M_R_A16);
      enq_item.mode        = req_addr_mode;
      enq_item.first_sel   = req_first_reg;
      enq_item.second_sel  = req_second_reg;
      enq_item.bus_byte    = req_bus_byte;
      enq_item.write_sel   = req_write_reg;
      enq_item.write_value = req_write_value;
   end

endmodule

>>> rtl/cofu_back.sv
module cofu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_empty,
   input  cofu_pkg::item_type   in_item,
   output logic                 in_pop,
   input  logic                 out_space,
   output logic                 out_push,
   output cofu_pkg::result_type out_result
);

   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_PC_FINAL   = 3'd1;
   localparam logic [2:0] PH_ADDR_FINAL = 3'd2;
   localparam logic [2:0] PH_LOW        = 3'd3;
   localparam logic [2:0] PH_HIGH       = 3'd4;

   cofu_pkg::arch_type arch_ff, arch_in;
   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  mode_ff, mode_in;
   logic [3:0]  first_ff, first_in;
   logic [3:0]  second_ff, second_in;
   logic [7:0]  low_ff, low_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [15:0] pend_addr_ff, pend_addr_in;

   cofu_pkg::arch_type arch_step;
   cofu_pkg::result_type res;
   logic        res_valid;
   logic        fire;
   logic [15:0] hl_now;
   logic [15:0] start_first;
   logic [15:0] start_second;
   logic [15:0] word;

   assign fire     = !in_empty && out_space;
   assign in_pop   = fire;
   assign out_push = fire && res_valid;
   assign out_result = res;

   // shared operand reads
   always_comb begin
      arch_step    = arch_ff;
      arch_step.pc = arch_ff.pc + 16'd1;
      hl_now       = cofu_pkg::read_reg(arch_ff, cofu_pkg::SEL_HL);
      start_first  = cofu_pkg::read_reg(arch_ff, in_item.first_sel);
      start_second = cofu_pkg::read_reg(arch_ff, in_item.second_sel);
      word         = {in_item.bus_byte, low_ff};
   end

   // execute one beat
   always_comb begin
      arch_in       = arch_ff;
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      low_in        = low_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      res           = '0;
      res_valid     = 1'b0;
      if (fire) begin
         case (in_item.op)
            cofu_pkg::ACT_START: begin
               phase_in      = PH_IDLE;
               pend_valid_in = 1'b0;
               pend_addr_in  = '0;
               res_valid     = 1'b1;
               res.kind      = cofu_pkg::KIND_DONE;
               if (!in_item.has_instr) begin
                  res.kind = cofu_pkg::KIND_DONE;
               end else if (in_item.mode_bad) begin
                  res.kind = cofu_pkg::KIND_BAD;
               end else begin
                  mode_in   = in_item.mode;
                  first_in  = in_item.first_sel;
                  second_in = in_item.second_sel;
                  case (in_item.mode) inside
                     cofu_pkg::M_IMP: begin
                     end
                     cofu_pkg::M_R: begin
                        res.operand_value = start_first;
                     end
                     cofu_pkg::M_R_R: begin
                        res.operand_value = start_second;
                     end
                     cofu_pkg::M_R_D8, cofu_pkg::M_R_A8, cofu_pkg::M_A8_R,
                     cofu_pkg::M_HL_SPR, cofu_pkg::M_D8, cofu_pkg::M_MR_D8: begin
                        res.kind        = cofu_pkg::KIND_BUS_REQ;
                        res.bus_address = arch_ff.pc;
                        phase_in        = PH_PC_FINAL;
                     end
                     cofu_pkg::M_R_D16, cofu_pkg::M_D16, cofu_pkg::M_A16_R,
                     cofu_pkg::M_D16_R, cofu_pkg::M_R_A16: begin
                        res.kind        = cofu_pkg::KIND_BUS_REQ;
                        res.bus_address = arch_ff.pc;
                        phase_in        = PH_LOW;
                     end
                     cofu_pkg::M_MR_R: begin
                        res.operand_value  = start_second;
                        res.dest_address   = start_first |
                           ((in_item.first_sel == cofu_pkg::SEL_C) ?
                            cofu_pkg::HIGH_PAGE : 16'h0000);
                        res.dest_is_memory = 1'b1;
                     end
                     cofu_pkg::M_R_MR: begin
                        res.kind        = cofu_pkg::KIND_BUS_REQ;
                        res.bus_address = start_second |
                           ((in_item.second_sel == cofu_pkg::SEL_C) ?
                            cofu_pkg::HIGH_PAGE : 16'h0000);
                        phase_in        = PH_ADDR_FINAL;
                     end
                     cofu_pkg::M_R_HLI, cofu_pkg::M_R_HLD: begin
                        res.kind        = cofu_pkg::KIND_BUS_REQ;
                        res.bus_address = start_second;
                        phase_in        = PH_ADDR_FINAL;
                     end
                     cofu_pkg::M_HLI_R, cofu_pkg::M_HLD_R: begin
                        res.operand_value  = start_second;
                        res.dest_address   = start_first;
                        res.dest_is_memory = 1'b1;
                        arch_in = cofu_pkg::write_reg(arch_ff, cofu_pkg::SEL_HL,
                           (in_item.mode == cofu_pkg::M_HLI_R) ?
                           hl_now + 16'd1 : hl_now - 16'd1);
                     end
                     default: begin
                        // memory read through first register, written back there
                        res.kind        = cofu_pkg::KIND_BUS_REQ;
                        res.bus_address = start_first;
                        pend_valid_in   = 1'b1;
                        pend_addr_in    = start_first;
                        phase_in        = PH_ADDR_FINAL;
                     end
                  endcase
               end
            end
            cofu_pkg::ACT_DATA: begin
               phase_in = PH_IDLE;
               case (phase_ff)
                  PH_PC_FINAL: begin
                     arch_in   = arch_step;
                     res_valid = 1'b1;
                     res.kind  = cofu_pkg::KIND_DONE;
                     if (mode_ff == cofu_pkg::M_A8_R) begin
                        res.dest_address   = {8'h00, in_item.bus_byte} | cofu_pkg::HIGH_PAGE;
                        res.dest_is_memory = 1'b1;
                     end else if (mode_ff == cofu_pkg::M_MR_D8) begin
                        res.operand_value  = {8'h00, in_item.bus_byte};
                        res.dest_address   = cofu_pkg::read_reg(arch_step, first_ff);
                        res.dest_is_memory = 1'b1;
                     end else begin
                        res.operand_value = {8'h00, in_item.bus_byte};
                     end
                  end
                  PH_ADDR_FINAL: begin
                     res_valid         = 1'b1;
                     res.kind          = cofu_pkg::KIND_DONE;
                     res.operand_value = {8'h00, in_item.bus_byte};
                     if (mode_ff == cofu_pkg::M_R_HLI || mode_ff == cofu_pkg::M_R_HLD) begin
                        arch_in = cofu_pkg::write_reg(arch_ff, cofu_pkg::SEL_HL,
                           (mode_ff == cofu_pkg::M_R_HLI) ?
                           hl_now + 16'd1 : hl_now - 16'd1);
                     end else if (mode_ff == cofu_pkg::M_MR && pend_valid_ff) begin
                        res.dest_address   = pend_addr_ff;
                        res.dest_is_memory = 1'b1;
                     end
                  end
                  PH_LOW: begin
                     low_in          = in_item.bus_byte;
                     arch_in         = arch_step;
                     res_valid       = 1'b1;
                     res.kind        = cofu_pkg::KIND_BUS_REQ;
                     res.bus_address = arch_step.pc;
                     phase_in        = PH_HIGH;
                  end
                  PH_HIGH: begin
                     arch_in   = arch_step;
                     res_valid = 1'b1;
                     res.kind  = cofu_pkg::KIND_DONE;
                     if (mode_ff == cofu_pkg::M_A16_R || mode_ff == cofu_pkg::M_D16_R) begin
                        res.operand_value  = cofu_pkg::read_reg(arch_step, second_ff);
                        res.dest_address   = word;
                        res.dest_is_memory = 1'b1;
                     end else if (mode_ff == cofu_pkg::M_R_A16) begin
                        res.kind        = cofu_pkg::KIND_BUS_REQ;
                        res.bus_address = word;
                        phase_in        = PH_ADDR_FINAL;
                     end else begin
                        res.operand_value = word;
                     end
                  end
                  default: begin
                     // data beat with no read outstanding
                     res_valid = 1'b0;
                  end
               endcase
            end
            cofu_pkg::ACT_WRITE: begin
               arch_in = cofu_pkg::write_reg(arch_ff, in_item.write_sel, in_item.write_value);
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff       <= '0;
         phase_ff      <= PH_IDLE;
         mode_ff       <= '0;
         first_ff      <= '0;
         second_ff     <= '0;
         low_ff        <= '0;
         pend_valid_ff <= 1'b0;
         pend_addr_ff  <= '0;
      end else begin
         arch_ff       <= arch_in;
         phase_ff      <= phase_in;
         mode_ff       <= mode_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         low_ff        <= low_in;
         pend_valid_ff <= pend_valid_in;
         pend_addr_ff  <= pend_addr_in;
      end
   end

endmodule

>>> rtl/cpu_operand_fetch_unit.sv
// Operand fetch unit with its own register file, SP, PC and fetch sequencer.
// Request side is a queue write port: a beat is taken on a clock edge with
// req_push high and req_full low. A beat starts a fetch, returns a bus byte
// for the outstanding read, or writes the register file.
// Response side is a queue read port: while rsp_empty is low the oldest
// response sits on the rsp_ ports and is taken on an edge with rsp_pop high.
// A response is a bus read request, a completed operand, or an unknown-mode
// error; register writes, stray bus bytes and unused actions give none.
// A classifier feeds a short request queue; the execute stage drains one
// beat per cycle into a response queue while it has space, so each side
// stalls on its own. Beats are registered in the request queue, responses in the response queue.
// Throughput: one beat per cycle while the response queue has space.
// When responses are not popped, the response queue fills, then the request
// queue, and req_full rises; nothing is dropped.
// Reset clears all registers to zero, the sequencer to idle and both queues.
module cpu_operand_fetch_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_action,
   input  logic        req_has_instruction,
   input  logic [4:0]  req_addr_mode,
   input  logic [3:0]  req_first_reg,
   input  logic [3:0]  req_second_reg,
   input  logic [7:0]  req_bus_byte,
   input  logic [3:0]  req_write_reg,
   input  logic [15:0] req_write_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_bus_address,
   output logic [15:0] rsp_operand_value,
   output logic [15:0] rsp_destination_address,
   output logic        rsp_destination_is_memory
);

   localparam int ITEM_W   = $bits(cofu_pkg::item_type);
   localparam int RESULT_W = $bits(cofu_pkg::result_type);

   logic                 enq_valid;
   cofu_pkg::item_type   enq_item;
   logic [ITEM_W-1:0]    head_bits;
   cofu_pkg::item_type   head_item;
   logic                 in_empty;
   logic                 in_pop;
   logic                 out_full;
   logic                 out_space;
   logic                 out_push;
   cofu_pkg::result_type out_result;
   logic [RESULT_W-1:0]  rsp_bits;
   cofu_pkg::result_type rsp_item;
   logic                 rsp_take;

   // classify incoming beats
   cofu_front u_front (
      .req_push            (req_push),
      .queue_full          (req_full),
      .req_action          (req_action),
      .req_has_instruction (req_has_instruction),
      .req_addr_mode       (req_addr_mode),
      .req_first_reg       (req_first_reg),
      .req_second_reg      (req_second_reg),
      .req_bus_byte        (req_bus_byte),
      .req_write_reg       (req_write_reg),
      .req_write_value     (req_write_value),
      .enq_valid           (enq_valid),
      .enq_item            (enq_item)
   );

   // request queue between front and back
   cofu_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_req_q (
      .clock     (clock),
      .reset     (reset),
      .push      (enq_valid),
      .push_data (enq_item),
      .pop       (in_pop),
      .pop_data  (head_bits),
      .full      (req_full),
      .empty     (in_empty)
   );

   assign head_item = cofu_pkg::item_type'(head_bits);
   assign out_space = !out_full || rsp_take;

   // execute stage
   cofu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_empty   (in_empty),
      .in_item    (head_item),
      .in_pop     (in_pop),
      .out_space  (out_space),
      .out_push   (out_push),
      .out_result (out_result)
   );

   // response queue
   cofu_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_result),
      .pop       (rsp_take),
      .pop_data  (rsp_bits),
      .full      (out_full),
      .empty     (rsp_empty)
   );

   assign rsp_take                  = rsp_pop && !rsp_empty;
   assign rsp_item                  = cofu_pkg::result_type'(rsp_bits);
   assign rsp_result_kind           = rsp_item.kind;
   assign rsp_bus_address           = rsp_item.bus_address;
   assign rsp_operand_value         = rsp_item.operand_value;
   assign rsp_destination_address   = rsp_item.dest_address;
   assign rsp_destination_is_memory = rsp_item.dest_is_memory;

endmodule

>>> test/tb_cpu_operand_fetch_unit.sv
module tb_cpu_operand_fetch_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // selector and action codes the package does not name
   localparam logic [3:0] SEL_BC     = 4'd10;
   localparam logic [3:0] SEL_UNUSED = 4'd15;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int RANDOM_BEATS   = 1700;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;

   // fetch sequencer phases of the shadow model
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_PC_FINAL   = 3'd1;
   localparam logic [2:0] PH_ADDR_FINAL = 3'd2;
   localparam logic [2:0] PH_LOW        = 3'd3;
   localparam logic [2:0] PH_HIGH       = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic        has_instr;
      logic [4:0]  mode;
      logic [3:0]  first_sel;
      logic [3:0]  second_sel;
      logic [7:0]  bus_byte;
      logic [3:0]  write_sel;
      logic [15:0] write_value;
   } req_beat_type;

   // shadow of the fetch unit plus the queue of responses it owes
   class operand_scoreboard;
      logic [7:0]           byte_regs [8];
      logic [15:0]          sp;
      logic [15:0]          pc;
      logic [2:0]           phase;
      logic [4:0]           held_mode;
      logic [3:0]           held_first;
      logic [3:0]           held_second;
      logic [7:0]           low_byte;
      logic                 pend_valid;
      logic [15:0]          pend_addr;
      cofu_pkg::result_type expected_responses [$];
      int                   mismatches;
      int                   response_count;

      function new();
         foreach (byte_regs[i]) byte_regs[i] = 8'h00;
         sp             = '0;
         pc             = '0;
         phase          = PH_IDLE;
         held_mode      = '0;
         held_first     = '0;
         held_second    = '0;
         low_byte       = '0;
         pend_valid     = 1'b0;
         pend_addr      = '0;
         mismatches     = 0;
         response_count = 0;
      endfunction

      function logic [15:0] reg_value(logic [3:0] sel);
         int pair;
         if (sel >= cofu_pkg::SEL_A && sel <= cofu_pkg::SEL_L)
            return {8'h00, byte_regs[sel - cofu_pkg::SEL_A]};
         if (sel >= cofu_pkg::SEL_AF && sel <= cofu_pkg::SEL_HL) begin
            pair = 2 * (sel - cofu_pkg::SEL_AF);
            return {byte_regs[pair], byte_regs[pair + 1]};
         end
         if (sel == cofu_pkg::SEL_SP) return sp;
         if (sel == cofu_pkg::SEL_PC) return pc;
         return 16'h0000;
      endfunction

      function void reg_store(logic [3:0] sel, logic [15:0] v);
         int pair;
         if (sel >= cofu_pkg::SEL_A && sel <= cofu_pkg::SEL_L) begin
            byte_regs[sel - cofu_pkg::SEL_A] = v[7:0];
         end else if (sel >= cofu_pkg::SEL_AF && sel <= cofu_pkg::SEL_HL) begin
            pair = 2 * (sel - cofu_pkg::SEL_AF);
            byte_regs[pair]     = v[15:8];
            byte_regs[pair + 1] = v[7:0];
         end else if (sel == cofu_pkg::SEL_SP) begin
            sp = v;
         end else if (sel == cofu_pkg::SEL_PC) begin
            pc = v;
         end
      endfunction

      function void bump_hl(bit up);
         logic [15:0] hl;
         hl = reg_value(cofu_pkg::SEL_HL);
         reg_store(cofu_pkg::SEL_HL, up ? hl + 16'd1 : hl - 16'd1);
      endfunction

      function void ask_bus(logic [2:0] next, logic [15:0] addr,
                            ref cofu_pkg::result_type r);
         phase         = next;
         r.kind        = cofu_pkg::KIND_BUS_REQ;
         r.bus_address = addr;
      endfunction

      function void finish_fetch(logic [15:0] op, logic [15:0] dest, logic mem,
                                 ref cofu_pkg::result_type r);
         phase            = PH_IDLE;
         r.kind           = cofu_pkg::KIND_DONE;
         r.operand_value  = op;
         r.dest_address   = dest;
         r.dest_is_memory = mem;
      endfunction

      // next state and response for one accepted beat; returns 0 when none
      function bit predict_fetch_response(req_beat_type b, ref cofu_pkg::result_type r);
         logic [15:0] addr;
         logic [15:0] op;
         logic [15:0] word;
         r = '0;
         if (b.action == cofu_pkg::ACT_WRITE) begin
            reg_store(b.write_sel, b.write_value);
            return 1'b0;
         end
         if (b.action == ACT_UNUSED) return 1'b0;

         if (b.action == cofu_pkg::ACT_START) begin
            phase      = PH_IDLE;
            pend_valid = 1'b0;
            pend_addr  = '0;
            if (!b.has_instr) begin
               finish_fetch('0, '0, 1'b0, r);
               return 1'b1;
            end
            if (b.mode > cofu_pkg::M_R_A16) begin
               r.kind = cofu_pkg::KIND_BAD;
               return 1'b1;
            end
            held_mode   = b.mode;
            held_first  = b.first_sel;
            held_second = b.second_sel;
            case (b.mode)
               cofu_pkg::M_IMP: finish_fetch('0, '0, 1'b0, r);
               cofu_pkg::M_R:   finish_fetch(reg_value(b.first_sel), '0, 1'b0, r);
               cofu_pkg::M_R_R: finish_fetch(reg_value(b.second_sel), '0, 1'b0, r);
               cofu_pkg::M_R_D8, cofu_pkg::M_R_A8, cofu_pkg::M_A8_R,
               cofu_pkg::M_HL_SPR, cofu_pkg::M_D8, cofu_pkg::M_MR_D8:
                  ask_bus(PH_PC_FINAL, pc, r);
               cofu_pkg::M_R_D16, cofu_pkg::M_D16, cofu_pkg::M_A16_R,
               cofu_pkg::M_D16_R, cofu_pkg::M_R_A16:
                  ask_bus(PH_LOW, pc, r);
               cofu_pkg::M_MR_R: begin
                  addr = reg_value(b.first_sel);
                  if (b.first_sel == cofu_pkg::SEL_C) addr |= cofu_pkg::HIGH_PAGE;
                  finish_fetch(reg_value(b.second_sel), addr, 1'b1, r);
               end
               cofu_pkg::M_R_MR: begin
                  addr = reg_value(b.second_sel);
                  if (b.second_sel == cofu_pkg::SEL_C) addr |= cofu_pkg::HIGH_PAGE;
                  ask_bus(PH_ADDR_FINAL, addr, r);
               end
               cofu_pkg::M_R_HLI, cofu_pkg::M_R_HLD:
                  ask_bus(PH_ADDR_FINAL, reg_value(b.second_sel), r);
               cofu_pkg::M_HLI_R, cofu_pkg::M_HLD_R: begin
                  op   = reg_value(b.second_sel);
                  addr = reg_value(b.first_sel);
                  bump_hl(b.mode == cofu_pkg::M_HLI_R);
                  finish_fetch(op, addr, 1'b1, r);
               end
               default: begin
                  // memory operand: destination is the address read from
                  addr       = reg_value(b.first_sel);
                  pend_valid = 1'b1;
                  pend_addr  = addr;
                  ask_bus(PH_ADDR_FINAL, addr, r);
               end
            endcase
            return 1'b1;
         end

         // bus byte returned
         case (phase)
            PH_PC_FINAL: begin
               pc = pc + 16'd1;
               if (held_mode == cofu_pkg::M_A8_R)
                  finish_fetch('0, {8'h00, b.bus_byte} | cofu_pkg::HIGH_PAGE, 1'b1, r);
               else if (held_mode == cofu_pkg::M_MR_D8)
                  finish_fetch({8'h00, b.bus_byte}, reg_value(held_first), 1'b1, r);
               else
                  finish_fetch({8'h00, b.bus_byte}, '0, 1'b0, r);
            end
            PH_ADDR_FINAL: begin
               if (held_mode == cofu_pkg::M_R_HLI || held_mode == cofu_pkg::M_R_HLD) begin
                  bump_hl(held_mode == cofu_pkg::M_R_HLI);
                  finish_fetch({8'h00, b.bus_byte}, '0, 1'b0, r);
               end else if (held_mode == cofu_pkg::M_MR && pend_valid) begin
                  finish_fetch({8'h00, b.bus_byte}, pend_addr, 1'b1, r);
               end else begin
                  finish_fetch({8'h00, b.bus_byte}, '0, 1'b0, r);
               end
            end
            PH_LOW: begin
               low_byte = b.bus_byte;
               pc       = pc + 16'd1;
               ask_bus(PH_HIGH, pc, r);
            end
            PH_HIGH: begin
               pc   = pc + 16'd1;
               word = {b.bus_byte, low_byte};
               if (held_mode == cofu_pkg::M_A16_R || held_mode == cofu_pkg::M_D16_R)
                  finish_fetch(reg_value(held_second), word, 1'b1, r);
               else if (held_mode == cofu_pkg::M_R_A16)
                  ask_bus(PH_ADDR_FINAL, word, r);
               else
                  finish_fetch(word, '0, 1'b0, r);
            end
            default: begin
               // stray byte with nothing outstanding
               phase = PH_IDLE;
               return 1'b0;
            end
         endcase
         return 1'b1;
      endfunction

      function void note_request(req_beat_type b);
         cofu_pkg::result_type r;
         if (predict_fetch_response(b, r)) expected_responses.push_back(r);
      endfunction

      task report(string msg);
         $display("[%0t] response %0d: %s", $time, response_count, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("%s got %h expected %h", name, got, want));
      endtask

      task check_response(cofu_pkg::result_type got);
         cofu_pkg::result_type want;
         if (expected_responses.size() == 0) begin
            report("response with nothing expected");
         end else begin
            want = expected_responses.pop_front();
            compare_field("result_kind", 16'(got.kind), 16'(want.kind));
            compare_field("bus_address", got.bus_address, want.bus_address);
            compare_field("operand_value", got.operand_value, want.operand_value);
            compare_field("destination_address", got.dest_address, want.dest_address);
            compare_field("destination_is_memory", 16'(got.dest_is_memory),
                          16'(want.dest_is_memory));
         end
         response_count++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_action = cofu_pkg::ACT_WRITE;
   logic        req_has_instruction = 1'b0;
   logic [4:0]  req_addr_mode = cofu_pkg::M_IMP;
   logic [3:0]  req_first_reg = cofu_pkg::SEL_NONE;
   logic [3:0]  req_second_reg = cofu_pkg::SEL_NONE;
   logic [7:0]  req_bus_byte = 8'h00;
   logic [3:0]  req_write_reg = cofu_pkg::SEL_NONE;
   logic [15:0] req_write_value = 16'h0000;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_bus_address;
   logic [15:0] rsp_operand_value;
   logic [15:0] rsp_destination_address;
   logic        rsp_destination_is_memory;

   operand_scoreboard    sb;
   bit                   drain_all = 1'b0;
   int                   idle_cycles = 0;
   int                   pop_style = 0;
   int                   style_left = 0;
   int                   stripe = 0;
   int                   burst_left = 0;
   cofu_pkg::result_type seen;

   always #4 clock = ~clock;

   cpu_operand_fetch_unit u_dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_push                  (req_push),
      .req_full                  (req_full),
      .req_action                (req_action),
      .req_has_instruction       (req_has_instruction),
      .req_addr_mode             (req_addr_mode),
      .req_first_reg             (req_first_reg),
      .req_second_reg            (req_second_reg),
      .req_bus_byte              (req_bus_byte),
      .req_write_reg             (req_write_reg),
      .req_write_value           (req_write_value),
      .rsp_empty                 (rsp_empty),
      .rsp_pop                   (rsp_pop),
      .rsp_result_kind           (rsp_result_kind),
      .rsp_bus_address           (rsp_bus_address),
      .rsp_operand_value         (rsp_operand_value),
      .rsp_destination_address   (rsp_destination_address),
      .rsp_destination_is_memory (rsp_destination_is_memory)
   );

   // fields the action does not use still carry random bits
   function automatic req_beat_type noise_beat();
      req_beat_type b;
      b.action      = 2'($urandom_range(0, 3));
      b.has_instr   = 1'($urandom_range(0, 1));
      b.mode        = 5'($urandom_range(0, 31));
      b.first_sel   = 4'($urandom_range(0, 15));
      b.second_sel  = 4'($urandom_range(0, 15));
      b.bus_byte    = 8'($urandom_range(0, 255));
      b.write_sel   = 4'($urandom_range(0, 15));
      b.write_value = 16'($urandom_range(0, 65535));
      return b;
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 16'hFFFF;
         1:       return 16'h0000;
         2:       return 16'hFFFE;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // hold the beat until the unit takes it, then update the shadow
   task automatic send_beat(req_beat_type b);
      req_push            <= 1'b1;
      req_action          <= b.action;
      req_has_instruction <= b.has_instr;
      req_addr_mode       <= b.mode;
      req_first_reg       <= b.first_sel;
      req_second_reg      <= b.second_sel;
      req_bus_byte        <= b.bus_byte;
      req_write_reg       <= b.write_sel;
      req_write_value     <= b.write_value;
      do @(posedge clock); while (req_full);
      sb.note_request(b);
   endtask

   task automatic send_start(logic instr, logic [4:0] mode, logic [3:0] r1, logic [3:0] r2);
      req_beat_type b;
      b            = noise_beat();
      b.action     = cofu_pkg::ACT_START;
      b.has_instr  = instr;
      b.mode       = mode;
      b.first_sel  = r1;
      b.second_sel = r2;
      send_beat(b);
   endtask

   task automatic send_data(logic [7:0] value);
      req_beat_type b;
      b          = noise_beat();
      b.action   = cofu_pkg::ACT_DATA;
      b.bus_byte = value;
      send_beat(b);
   endtask

   task automatic send_write(logic [3:0] sel, logic [15:0] value);
      req_beat_type b;
      b             = noise_beat();
      b.action      = cofu_pkg::ACT_WRITE;
      b.write_sel   = sel;
      b.write_value = value;
      send_beat(b);
   endtask

   task automatic send_unused();
      req_beat_type b;
      b        = noise_beat();
      b.action = ACT_UNUSED;
      send_beat(b);
   endtask

   task automatic random_start();
      logic [4:0] mode;
      mode = ($urandom_range(0, 99) < 94) ? 5'($urandom_range(0, 20))
                                           : 5'($urandom_range(21, 31));
      send_start($urandom_range(0, 19) != 0, mode,
                 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
   endtask

   // bursts of beats with idle gaps between them
   task automatic sender_pause();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // response side: check each popped beat, then pick the next pop
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         seen.kind           = rsp_result_kind;
         seen.bus_address    = rsp_bus_address;
         seen.operand_value  = rsp_operand_value;
         seen.dest_address   = rsp_destination_address;
         seen.dest_is_memory = rsp_destination_is_memory;
         sb.check_response(seen);
      end
      stripe++;
      if (style_left == 0) begin
         pop_style  = $urandom_range(0, 3);
         style_left = $urandom_range(50, 300);
      end else begin
         style_left--;
      end
      if (drain_all) begin
         rsp_pop <= 1'b1;
      end else begin
         case (pop_style)
            0:       rsp_pop <= 1'b1;
            1:       rsp_pop <= 1'($urandom_range(0, 1));
            2:       rsp_pop <= (stripe % 7) < 2;
            default: rsp_pop <= (stripe % 32) >= 22;
         endcase
      end
   end

   // watchdog on cycles where neither side moves a beat
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int counted;
      int roll;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no instruction, unknown modes, wraps, high page, ignored beats
      send_start(1'b0, cofu_pkg::M_MR, cofu_pkg::SEL_HL, cofu_pkg::SEL_A);
      send_start(1'b1, 5'd31, cofu_pkg::SEL_A, cofu_pkg::SEL_A);
      send_write(cofu_pkg::SEL_PC, 16'hFFFF);
      send_write(cofu_pkg::SEL_HL, 16'hFFFF);
      send_write(SEL_BC, 16'h12FF);
      send_write(cofu_pkg::SEL_NONE, 16'hBEEF);
      send_write(SEL_UNUSED, 16'hBEEF);
      send_start(1'b1, cofu_pkg::M_R_D16, cofu_pkg::SEL_A, cofu_pkg::SEL_NONE);
      send_data(8'h00);
      send_data(8'hFF);
      send_start(1'b1, cofu_pkg::M_HLI_R, cofu_pkg::SEL_HL, SEL_UNUSED);
      send_start(1'b1, cofu_pkg::M_HLD_R, cofu_pkg::SEL_HL, cofu_pkg::SEL_SP);
      send_start(1'b1, cofu_pkg::M_MR_R, cofu_pkg::SEL_C, cofu_pkg::SEL_A);
      send_start(1'b1, cofu_pkg::M_A8_R, cofu_pkg::SEL_NONE, cofu_pkg::SEL_A);
      send_data(8'hFF);
      send_data(8'h5A);
      send_unused();
      send_start(1'b1, cofu_pkg::M_R_D8, cofu_pkg::SEL_A, cofu_pkg::SEL_NONE);
      send_start(1'b1, cofu_pkg::M_R_MR, cofu_pkg::SEL_A, cofu_pkg::SEL_C);
      send_data(8'h80);
      send_start(1'b1, cofu_pkg::M_MR, cofu_pkg::SEL_HL, cofu_pkg::SEL_NONE);
      send_data(8'h01);
      send_start(1'b1, cofu_pkg::M_R_A16, cofu_pkg::SEL_A, cofu_pkg::SEL_NONE);
      send_data(8'h34);
      send_data(8'h12);
      send_data(8'hC3);

      // random: mostly complete fetches, with writes, restarts and noise
      counted = 0;
      while (counted < RANDOM_BEATS) begin
         roll = $urandom_range(0, 99);
         if (sb.phase != PH_IDLE) begin
            if (roll < 82) begin
               send_data(8'($urandom_range(0, 255)));
               counted++;
            end else if (roll < 90) begin
               send_write(4'($urandom_range(0, 15)), pick_value());
               counted++;
            end else if (roll < 96) begin
               random_start();
               counted++;
            end else begin
               send_unused();
            end
         end else begin
            if (roll < 70) begin
               random_start();
               counted++;
            end else if (roll < 88) begin
               send_write(4'($urandom_range(0, 15)), pick_value());
               counted++;
            end else if (roll < 95) begin
               send_data(8'($urandom_range(0, 255)));
            end else begin
               send_unused();
            end
         end
         sender_pause();
      end
      req_push <= 1'b0;

      // drain, then let the pipeline settle to catch stray responses
      drain_all = 1'b1;
      while (sb.expected_responses.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/cofu_pkg.sv
rtl/cofu_fifo.sv
rtl/cofu_front.sv
rtl/cofu_back.sv
rtl/cpu_operand_fetch_unit.sv
test/tb_cpu_operand_fetch_unit.sv
